// ----- hw/rtl/psm_pkg.sv -----
// Package for the prefix schema loader and matcher.
// Holds sizes, header codes, state and queue types; no dependencies.
`default_nettype none

package psm_pkg;

  // Prefix table geometry
  localparam int TABLE_DEPTH = 256;
  localparam int TBL_ADDR_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int ROW_W       = 40;
  localparam int ROW_BYTES   = 5;
  localparam int ROW_BYTE_W  = 3;
  localparam int ROW_IDX_W   = 9;   // row counter runs past the table when blob is long
  localparam int SCAN_W      = 9;   // holds a count of up to 256

  // Blob framing
  localparam int HDR_LEN = 13;
  localparam int POS_W   = 11;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  // Header byte positions
  localparam logic [3:0] HP_MAGIC0  = 4'd0;
  localparam logic [3:0] HP_MAGIC1  = 4'd1;
  localparam logic [3:0] HP_MAGIC2  = 4'd2;
  localparam logic [3:0] HP_MAGIC3  = 4'd3;
  localparam logic [3:0] HP_VER_LO  = 4'd4;
  localparam logic [3:0] HP_VER_HI  = 4'd5;
  localparam logic [3:0] HP_ROW0    = 4'd6;
  localparam logic [3:0] HP_ROW1    = 4'd7;
  localparam logic [3:0] HP_CLASS   = 4'd8;
  localparam logic [3:0] HP_REALM   = 4'd9;
  localparam logic [3:0] HP_EPOCH_L = 4'd10;
  localparam logic [3:0] HP_EPOCH_H = 4'd11;
  localparam logic [3:0] HP_COUNT   = 4'd12;

  // Expected header byte values
  localparam logic [7:0] MAGIC0     = 8'h54;  // 'T'
  localparam logic [7:0] MAGIC1     = 8'h41;  // 'A'
  localparam logic [7:0] MAGIC2     = 8'h44;  // 'D'
  localparam logic [7:0] MAGIC3     = 8'h52;  // 'R'
  localparam logic [7:0] VERSION_LO = 8'd2;
  localparam logic [7:0] VERSION_HI = 8'd0;
  localparam logic [7:0] ROW_HDR0   = 8'd8;
  localparam logic [7:0] ROW_HDR1   = 8'd5;

  // Front-to-back queue
  localparam int QUEUE_DEPTH = 2;
  localparam int Q_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int Q_FILL_W    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    FUNC_BLOB  = 1'b0,
    FUNC_QUERY = 1'b1
  } func_t;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } back_state_t;

  typedef struct packed {
    func_t            func;
    logic [7:0]       blob_byte;
    logic             blob_last;
    logic [ROW_W-1:0] addr_prefix;
  } item_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic  avail;
    item_t item;
  } q_head_t;

  typedef struct packed {
    logic        done;
    kind_t       kind;
    logic        load_ok;
    logic        match;
    logic [7:0]  class_byte;
    logic [7:0]  realm;
    logic [15:0] epoch;
  } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/psm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module psm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                           wr_data,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output      logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/psm_front.sv -----
// Front end: accepts command transactions, tags them and queues them.
// Depends on psm_pkg.
`default_nettype none

module psm_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output      logic                          busy,
  input  wire logic                          func,
  input  wire logic [7:0]                    blob_byte,
  input  wire logic                          blob_last,
  input  wire logic [psm_pkg::ROW_W-1:0]     addr_prefix,
  output      psm_pkg::q_head_t              head,
  input  wire logic                          pop
);
  import psm_pkg::*;

  item_t               slots [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr;
  logic [Q_PTR_W-1:0]  rd_ptr;
  logic [Q_FILL_W-1:0] fill;
  logic                push;
  logic                take;
  item_t               incoming;

  assign busy = (fill == Q_FILL_W'(QUEUE_DEPTH));
  assign push = start && !busy;
  assign take = pop && (fill != '0);

  // Classify the command into a queue item
  always_comb begin
    incoming.func        = func ? FUNC_QUERY : FUNC_BLOB;
    incoming.blob_byte   = blob_byte;
    incoming.blob_last   = blob_last;
    incoming.addr_prefix = addr_prefix;
  end

  assign head.avail = (fill != '0);
  assign head.item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, take})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/psm_back.sv -----
// Back end: parses blob bytes, fills the prefix table and scans it for queries.
// Depends on psm_pkg and psm_ram.
`default_nettype none

module psm_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire psm_pkg::q_head_t head,
  output      logic             pop,
  output      psm_pkg::result_t res
);
  import psm_pkg::*;

  back_state_t state, state_next;

  logic [POS_W-1:0]      pos, pos_next;
  logic                  header_bad, header_bad_next;
  logic                  loaded, loaded_next;
  logic [7:0]            class_reg, class_reg_next;
  logic [7:0]            realm_reg, realm_reg_next;
  logic [15:0]           epoch_reg, epoch_reg_next;
  logic [7:0]            entry_count, entry_count_next;
  logic [ROW_BYTE_W-1:0] row_byte, row_byte_next;
  logic [ROW_IDX_W-1:0]  row_idx, row_idx_next;
  logic [31:0]           row_buf, row_buf_next;
  logic [SCAN_W-1:0]     rd_idx, rd_idx_next;
  logic                  found, found_next;
  logic [ROW_W-1:0]      q_addr, q_addr_next;
  result_t               res_next;

  logic                  ram_we;
  logic [TBL_ADDR_W-1:0] ram_waddr;
  logic [ROW_W-1:0]      ram_wdata;
  logic [TBL_ADDR_W-1:0] ram_raddr;
  logic [ROW_W-1:0]      ram_rdata;

  logic is_blob;
  logic is_query;
  logic eligible;
  logic scan_end;
  logic hit;

  psm_ram #(
    .WIDTH (ROW_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign is_blob  = (state == ST_IDLE) && head.avail && (head.item.func == FUNC_BLOB);
  assign is_query = (state == ST_IDLE) && head.avail && (head.item.func == FUNC_QUERY);
  assign eligible = loaded && (head.item.addr_prefix[7:0] == realm_reg);
  assign scan_end = (rd_idx == {1'b0, entry_count});
  assign hit      = (ram_rdata == q_addr);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (is_query && eligible) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    logic [11:0] len;
    logic [10:0] need;
    logic        ok;

    pop              = 1'b0;
    pos_next         = pos;
    header_bad_next  = header_bad;
    loaded_next      = loaded;
    class_reg_next   = class_reg;
    realm_reg_next   = realm_reg;
    epoch_reg_next   = epoch_reg;
    entry_count_next = entry_count;
    row_byte_next    = row_byte;
    row_idx_next     = row_idx;
    row_buf_next     = row_buf;
    rd_idx_next      = rd_idx;
    found_next       = found;
    q_addr_next      = q_addr;
    ram_we           = 1'b0;
    ram_waddr        = row_idx[TBL_ADDR_W-1:0];
    ram_wdata        = {head.item.blob_byte, row_buf};
    ram_raddr        = rd_idx[TBL_ADDR_W-1:0];
    res_next         = '0;
    len              = 12'(pos) + 12'd1;
    need             = '0;
    ok               = 1'b0;

    case (state)
      ST_IDLE: begin
        if (is_blob) begin
          pop = 1'b1;
          // First byte of a blob drops the old schema
          if (pos == '0) begin
            loaded_next     = 1'b0;
            header_bad_next = 1'b0;
          end
          if (pos < POS_W'(HDR_LEN)) begin
            case (pos[3:0])
              HP_MAGIC0:  if (head.item.blob_byte != MAGIC0)     header_bad_next = 1'b1;
              HP_MAGIC1:  if (head.item.blob_byte != MAGIC1)     header_bad_next = 1'b1;
              HP_MAGIC2:  if (head.item.blob_byte != MAGIC2)     header_bad_next = 1'b1;
              HP_MAGIC3:  if (head.item.blob_byte != MAGIC3)     header_bad_next = 1'b1;
              HP_VER_LO:  if (head.item.blob_byte != VERSION_LO) header_bad_next = 1'b1;
              HP_VER_HI:  if (head.item.blob_byte != VERSION_HI) header_bad_next = 1'b1;
              HP_ROW0:    if (head.item.blob_byte != ROW_HDR0)   header_bad_next = 1'b1;
              HP_ROW1:    if (head.item.blob_byte != ROW_HDR1)   header_bad_next = 1'b1;
              HP_CLASS:   class_reg_next = head.item.blob_byte;
              HP_REALM:   realm_reg_next = head.item.blob_byte;
              HP_EPOCH_L: epoch_reg_next = {epoch_reg[15:8], head.item.blob_byte};
              HP_EPOCH_H: epoch_reg_next = {head.item.blob_byte, epoch_reg[7:0]};
              default: begin
                entry_count_next = head.item.blob_byte;
                if ((head.item.blob_byte == 8'd0) ||
                    ({1'b0, head.item.blob_byte} > 9'(TABLE_DEPTH))) begin
                  header_bad_next = 1'b1;
                end
              end
            endcase
          end else begin
            // Gather row bytes; write the whole row on its last byte
            if (row_byte == ROW_BYTE_W'(ROW_BYTES - 1)) begin
              ram_we = (row_idx < {1'b0, entry_count}) &&
                       (row_idx < ROW_IDX_W'(TABLE_DEPTH));
            end else begin
              row_buf_next[{row_byte[1:0], 3'b000} +: 8] = head.item.blob_byte;
            end
            if (pos != POS_MAX) begin
              if (row_byte == ROW_BYTE_W'(ROW_BYTES - 1)) begin
                row_byte_next = '0;
                row_idx_next  = row_idx + 1'b1;
              end else begin
                row_byte_next = row_byte + 1'b1;
              end
            end
          end
          if (pos != POS_MAX) begin
            pos_next = pos + 1'b1;
          end

          if (head.item.blob_last) begin
            need = 11'(HDR_LEN) + {1'b0, entry_count_next, 2'b00} + {3'b000, entry_count_next};
            ok   = !header_bad_next && (len >= 12'(HDR_LEN)) && (len >= {1'b0, need});
            loaded_next     = ok;
            pos_next        = '0;
            row_byte_next   = '0;
            row_idx_next    = '0;
            header_bad_next = 1'b0;
            res_next.done       = 1'b1;
            res_next.kind       = KIND_LOAD;
            res_next.load_ok    = ok;
            res_next.class_byte = ok ? class_reg : 8'd0;
            res_next.realm      = ok ? realm_reg : 8'd0;
            res_next.epoch      = ok ? epoch_reg : 16'd0;
          end
        end else if (is_query) begin
          pop         = 1'b1;
          q_addr_next = head.item.addr_prefix;
          if (eligible) begin
            // Issue the read of entry zero and start the scan
            ram_raddr   = '0;
            rd_idx_next = SCAN_W'(1);
            found_next  = 1'b0;
          end else begin
            res_next.done       = 1'b1;
            res_next.kind       = KIND_QUERY;
            res_next.class_byte = loaded ? class_reg : 8'd0;
            res_next.realm      = loaded ? realm_reg : 8'd0;
            res_next.epoch      = loaded ? epoch_reg : 16'd0;
          end
        end
      end
      ST_SCAN: begin
        // Compare the entry read last cycle, issue the next one
        found_next = found || hit;
        if (scan_end) begin
          res_next.done       = 1'b1;
          res_next.kind       = KIND_QUERY;
          res_next.match      = found || hit;
          res_next.class_byte = class_reg;
          res_next.realm      = realm_reg;
          res_next.epoch      = epoch_reg;
        end else begin
          rd_idx_next = rd_idx + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      pos         <= '0;
      header_bad  <= 1'b0;
      loaded      <= 1'b0;
      class_reg   <= '0;
      realm_reg   <= '0;
      epoch_reg   <= '0;
      entry_count <= '0;
      row_byte    <= '0;
      row_idx     <= '0;
      rd_idx      <= '0;
      res         <= '0;
    end else begin
      state       <= state_next;
      pos         <= pos_next;
      header_bad  <= header_bad_next;
      loaded      <= loaded_next;
      class_reg   <= class_reg_next;
      realm_reg   <= realm_reg_next;
      epoch_reg   <= epoch_reg_next;
      entry_count <= entry_count_next;
      row_byte    <= row_byte_next;
      row_idx     <= row_idx_next;
      rd_idx      <= rd_idx_next;
      res         <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    row_buf <= row_buf_next;
    found   <= found_next;
    q_addr  <= q_addr_next;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/prefix_schema_load_and_match.sv -----
// Prefix schema loader and matcher.
// Commands enter on start/busy: func 0 carries one schema blob byte
// (blob_last ends the blob), func 1 carries a five-byte address prefix query.
// A command transaction is taken at a clock edge with start high and busy low;
// busy rises only when the two-entry command queue is full.
// Each result is presented for exactly one cycle with done high: a load
// result (kind 0, load_ok) for the last byte of a blob, a query result
// (kind 1, match) for every query. Class, realm and epoch read zero when no
// schema is loaded. The receiver cannot stall; results are never held.
// A load result is registered once the last byte of its blob leaves the queue.
// A query against a loaded schema whose realm matches scans the stored
// prefixes one per cycle through the table's registered read port; any
// other query is answered without a scan. Blob bytes go through at
// one per cycle while the back end is not scanning; a scanning query
// holds the back end until its last stored prefix has been compared.
// Reset (rst, synchronous) empties the queue and leaves no schema loaded;
// the prefix table itself is not cleared, since only rows written by the
// current schema are ever compared.
`default_nettype none

module prefix_schema_load_and_match (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output      logic        busy,
  input  wire logic        func,
  input  wire logic [7:0]  blob_byte,
  input  wire logic        blob_last,
  input  wire logic [39:0] addr_prefix,
  output      logic        done,
  output      logic        kind,
  output      logic        load_ok,
  output      logic        match,
  output      logic [7:0]  class_out,
  output      logic [7:0]  realm_out,
  output      logic [15:0] epoch_out
);
  import psm_pkg::*;

  q_head_t head;
  logic    pop;
  result_t res;

  // Front end: take the transaction and queue it
  psm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .func        (func),
    .blob_byte   (blob_byte),
    .blob_last   (blob_last),
    .addr_prefix (addr_prefix),
    .head        (head),
    .pop         (pop)
  );

  // Back end: parse blobs, hold the schema, scan the table
  psm_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .pop  (pop),
    .res  (res)
  );

  // Drive the result ports straight from the back end's output register
  assign done      = res.done;
  assign kind      = res.kind;
  assign load_ok   = res.load_ok;
  assign match     = res.match;
  assign class_out = res.class_byte;
  assign realm_out = res.realm;
  assign epoch_out = res.epoch;

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking bench for the prefix schema loader and matcher.
// Depends on psm_pkg and prefix_schema_load_and_match; drives start/busy
// commands and scores each done-strobed reply against a local predictor.
module tb_top;
  import psm_pkg::*;

  // One reply as the block presents it on its result ports
  typedef struct packed {
    kind_t       kind;
    logic        load_ok;
    logic        match;
    logic [7:0]  cls;
    logic [7:0]  realm;
    logic [15:0] epoch;
  } reply_t;

  // One row of the directed table; pinned rows carry a hand-written reply
  typedef struct {
    func_t       f;
    logic [7:0]  b;
    logic        last;
    logic [39:0] a;
    bit          pinned;
    reply_t      want;
  } step_t;

  typedef enum int {
    BLOB_GOOD,
    BLOB_BAD_HDR,
    BLOB_ZERO_COUNT,
    BLOB_SHORT,
    BLOB_NOISE
  } blob_shape_t;

  localparam reply_t NO_SCHEMA_QUERY = '{KIND_QUERY, 1'b0, 1'b0, 8'h00, 8'h00, 16'h0000};
  localparam reply_t FAILED_LOAD     = '{KIND_LOAD, 1'b0, 1'b0, 8'h00, 8'h00, 16'h0000};
  localparam int RANDOM_ITEMS = 280;
  localparam int STALL_LIMIT  = 2000;  // cycles without any transaction or reply
  localparam int DRAIN_LIMIT  = 1500;
  localparam int TAIL_CYCLES  = 300;   // covers the longest scan, of 255 rows
  localparam int MAX_PRINTS   = 30;

  // Clock, reset and the command side of the block
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  func_t       func = FUNC_BLOB;
  logic [7:0]  blob_byte = 8'h00;
  logic        blob_last = 1'b0;
  logic [39:0] addr_prefix = '0;
  logic        busy;
  logic        done;
  logic        kind;
  logic        load_ok;
  logic        match;
  logic [7:0]  class_out;
  logic [7:0]  realm_out;
  logic [15:0] epoch_out;

  // Hand-written reply travelling alongside the command it belongs to
  bit          pin_valid = 1'b0;
  reply_t      pin_reply = NO_SCHEMA_QUERY;

  prefix_schema_load_and_match dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .func        (func),
    .blob_byte   (blob_byte),
    .blob_last   (blob_last),
    .addr_prefix (addr_prefix),
    .done        (done),
    .kind        (kind),
    .load_ok     (load_ok),
    .match       (match),
    .class_out   (class_out),
    .realm_out   (realm_out),
    .epoch_out   (epoch_out)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------
  // Predictor: own copy of the loader state and the prefix table
  // ---------------------------------------------------------------------
  logic [10:0] pm_pos    = '0;
  bit          pm_bad    = 1'b0;
  bit          pm_loaded = 1'b0;
  logic [7:0]  pm_class  = '0;
  logic [7:0]  pm_realm  = '0;
  logic [15:0] pm_epoch  = '0;
  logic [7:0]  pm_count  = '0;
  logic [39:0] pm_rows [TABLE_DEPTH];

  reply_t replies_due [$];

  // Advance the predictor by one accepted command; return 1 if it yields a reply.
  function automatic bit predict_reply(input func_t f, input logic [7:0] b,
                                       input logic last, input logic [39:0] a,
                                       output reply_t r);
    logic [10:0] p;
    int          off;
    int          idx;
    int          len;
    int          need;
    int          i;
    bit          hit;
    bit          ok;
    r = NO_SCHEMA_QUERY;
    if (f == FUNC_QUERY) begin
      hit = 1'b0;
      // Scan only when a schema is present and the realm byte agrees
      if (pm_loaded && a[7:0] == pm_realm) begin
        for (i = 0; i < pm_count; i++)
          if (pm_rows[i] == a) hit = 1'b1;
      end
      r.kind  = KIND_QUERY;
      r.match = hit;
      if (pm_loaded) begin
        r.cls   = pm_class;
        r.realm = pm_realm;
        r.epoch = pm_epoch;
      end
      return 1'b1;
    end

    p = pm_pos;
    // First byte of a blob drops whatever schema was there
    if (p == 0) begin
      pm_loaded = 1'b0;
      pm_bad    = 1'b0;
    end
    if (p < HDR_LEN) begin
      case (p[3:0])
        HP_MAGIC0:  if (b != MAGIC0) pm_bad = 1'b1;
        HP_MAGIC1:  if (b != MAGIC1) pm_bad = 1'b1;
        HP_MAGIC2:  if (b != MAGIC2) pm_bad = 1'b1;
        HP_MAGIC3:  if (b != MAGIC3) pm_bad = 1'b1;
        HP_VER_LO:  if (b != VERSION_LO) pm_bad = 1'b1;
        HP_VER_HI:  if (b != VERSION_HI) pm_bad = 1'b1;
        HP_ROW0:    if (b != ROW_HDR0) pm_bad = 1'b1;
        HP_ROW1:    if (b != ROW_HDR1) pm_bad = 1'b1;
        HP_CLASS:   pm_class = b;
        HP_REALM:   pm_realm = b;
        HP_EPOCH_L: pm_epoch[7:0] = b;
        HP_EPOCH_H: pm_epoch[15:8] = b;
        default: begin
          pm_count = b;
          if (b == 0 || b > TABLE_DEPTH) pm_bad = 1'b1;
        end
      endcase
    end else begin
      off = p - HDR_LEN;
      idx = off / ROW_BYTES;
      if (idx < pm_count && idx < TABLE_DEPTH)
        pm_rows[idx][(off % ROW_BYTES) * 8 +: 8] = b;
    end
    if (pm_pos != POS_MAX) pm_pos = pm_pos + 1'b1;

    if (!last) return 1'b0;

    len  = p + 1;
    need = HDR_LEN + pm_count * ROW_BYTES;
    ok   = !pm_bad && len >= HDR_LEN && len >= need;
    pm_loaded = ok;
    pm_pos    = '0;
    pm_bad    = 1'b0;
    r.kind    = KIND_LOAD;
    r.load_ok = ok;
    if (ok) begin
      r.cls   = pm_class;
      r.realm = pm_realm;
      r.epoch = pm_epoch;
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Scoreboard: one process samples both handshakes at every rising edge,
  // retiring the oldest expectation before queueing the new one.
  // ---------------------------------------------------------------------
  int errors       = 0;
  int loads_seen   = 0;
  int loads_good   = 0;
  int queries_seen = 0;
  int hits_seen    = 0;

  task automatic report(string what, longint unsigned got, longint unsigned want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) report(name, got, want);
  endtask

  always @(posedge clk) begin
    reply_t due;
    reply_t fresh;
    if (!rst) begin
      if (done === 1'b1) begin
        if (replies_due.size() == 0) begin
          report("reply with nothing outstanding, kind", kind, 0);
        end else begin
          due = replies_due.pop_front();
          check_field("kind", kind, due.kind);
          check_field("load_ok", load_ok, due.load_ok);
          check_field("match", match, due.match);
          check_field("class_out", class_out, due.cls);
          check_field("realm_out", realm_out, due.realm);
          check_field("epoch_out", epoch_out, due.epoch);
          if (due.kind == KIND_LOAD) begin
            loads_seen++;
            if (due.load_ok) loads_good++;
          end else begin
            queries_seen++;
            if (due.match) hits_seen++;
          end
        end
      end
      // A pinned row overrides the predictor's reply but still advances its state
      if (start && !busy) begin
        if (predict_reply(func, blob_byte, blob_last, addr_prefix, fresh))
          replies_due.push_back(pin_valid ? pin_reply : fresh);
      end
    end
  end

  // Watchdog: give up when neither side has moved for too long
  int stall_cycles = 0;

  always @(posedge clk) begin
    if (rst || (start && !busy) || done === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Command driver
  // ---------------------------------------------------------------------
  bit          idle_gaps  = 1'b1;
  int          items_sent = 0;
  step_t       directed [$];
  logic [7:0]  blob_bytes [$];
  logic [39:0] recent_rows [$];
  logic [7:0]  recent_realm = '0;

  // Present one command and hold it until the block takes it. Leave start high
  // on return so back-to-back transactions need no extra edge.
  task automatic issue(input func_t f, input logic [7:0] b, input logic last,
                       input logic [39:0] a, input bit pinned, input reply_t want);
    if (idle_gaps && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    start       <= 1'b1;
    func        <= f;
    blob_byte   <= b;
    blob_last   <= last;
    addr_prefix <= a;
    pin_valid   <= pinned;
    pin_reply   <= want;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic add_step(input func_t f, input logic [7:0] b, input logic last,
                          input logic [39:0] a, input bit pinned, input reply_t want);
    step_t s;
    s.f = f;
    s.b = b;
    s.last = last;
    s.a = a;
    s.pinned = pinned;
    s.want = want;
    directed.push_back(s);
  endtask

  function automatic logic [39:0] random_addr();
    return {8'($urandom), 32'($urandom)};
  endfunction

  // Assemble a blob of the given shape into blob_bytes. pad_to stretches a
  // blob with junk up to that length; zero may add a short random tail.
  task automatic build_blob(input blob_shape_t shape, input int rows, input int pad_to);
    logic [7:0]  realm_b;
    logic [39:0] row;
    int          i;
    int          k;
    int          n;
    realm_b = 8'($urandom);
    blob_bytes = {};
    blob_bytes.push_back(MAGIC0);
    blob_bytes.push_back(MAGIC1);
    blob_bytes.push_back(MAGIC2);
    blob_bytes.push_back(MAGIC3);
    blob_bytes.push_back(VERSION_LO);
    blob_bytes.push_back(VERSION_HI);
    blob_bytes.push_back(ROW_HDR0);
    blob_bytes.push_back(ROW_HDR1);
    blob_bytes.push_back(8'($urandom));
    blob_bytes.push_back(realm_b);
    blob_bytes.push_back(8'($urandom));
    blob_bytes.push_back(8'($urandom));
    blob_bytes.push_back(8'(rows));
    if (shape == BLOB_GOOD) recent_rows = {};
    for (i = 0; i < rows; i++) begin
      // Most rows carry the realm so that hits are reachable; repeat one now and then
      if (i > 0 && $urandom_range(0, 9) == 0) begin
        row = recent_rows.size() > 0 ? recent_rows[$] : random_addr();
      end else begin
        row = random_addr();
        if ($urandom_range(0, 4) != 0) row[7:0] = realm_b;
      end
      for (k = 0; k < ROW_BYTES; k++) blob_bytes.push_back(row[8 * k +: 8]);
      if (shape == BLOB_GOOD) recent_rows.push_back(row);
    end
    if (shape == BLOB_GOOD) recent_realm = realm_b;
    if (pad_to > 0) begin
      while (blob_bytes.size() < pad_to) blob_bytes.push_back(8'($urandom));
    end else if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 6)) blob_bytes.push_back(8'($urandom));
    end
    case (shape)
      BLOB_BAD_HDR: begin
        k = $urandom_range(0, 7);
        blob_bytes[k] = blob_bytes[k] ^ 8'($urandom_range(1, 255));
      end
      BLOB_ZERO_COUNT: blob_bytes[HP_COUNT] = 8'h00;
      BLOB_SHORT: begin
        n = $urandom_range(1, blob_bytes.size() - 1);
        while (blob_bytes.size() > n) void'(blob_bytes.pop_back());
      end
      BLOB_NOISE: begin
        blob_bytes = {};
        repeat ($urandom_range(1, 24)) blob_bytes.push_back(8'($urandom));
        if ($urandom_range(0, 1) == 0) blob_bytes[0] = MAGIC0;
      end
      default: ;
    endcase
  endtask

  task automatic send_query();
    logic [39:0] a;
    int          sel;
    a = random_addr();
    sel = $urandom_range(0, 99);
    if (recent_rows.size() > 0) begin
      if (sel < 45) begin
        a = recent_rows[$urandom_range(0, recent_rows.size() - 1)];
      end else if (sel < 65) begin
        // Near miss: realm and most bytes right, one later byte wrong
        a = recent_rows[$urandom_range(0, recent_rows.size() - 1)];
        a[8 * $urandom_range(1, 4) +: 8] ^= 8'($urandom_range(1, 255));
      end else if (sel < 80) begin
        a[7:0] = recent_realm;
      end
    end
    issue(FUNC_QUERY, 8'($urandom), 1'($urandom), a, 1'b0, NO_SCHEMA_QUERY);
  endtask

  // Stream blob_bytes out, now and then slipping a query in mid-load
  task automatic send_blob();
    int i;
    for (i = 0; i < blob_bytes.size(); i++) begin
      if ($urandom_range(0, 14) == 0) send_query();
      issue(FUNC_BLOB, blob_bytes[i], i == blob_bytes.size() - 1, random_addr(),
            1'b0, NO_SCHEMA_QUERY);
    end
  endtask

  task automatic random_episode();
    int          pick;
    blob_shape_t shape;
    pick = $urandom_range(0, 99);
    if (pick < 65)      shape = BLOB_GOOD;
    else if (pick < 73) shape = BLOB_BAD_HDR;
    else if (pick < 79) shape = BLOB_ZERO_COUNT;
    else if (pick < 89) shape = BLOB_SHORT;
    else                shape = BLOB_NOISE;
    build_blob(shape, $urandom_range(0, 5) == 0 ? $urandom_range(5, 12)
                                                : $urandom_range(1, 4), 0);
    send_blob();
    repeat ($urandom_range(1, 6)) send_query();
  endtask

  initial begin
    int w;

    // Directed table: empty block, failed loads, one full load with a query
    // landing mid-blob, then hit and miss queries against the new schema.
    add_step(FUNC_QUERY, 8'h00, 1'b0, 40'h00_0000_0000, 1'b1, NO_SCHEMA_QUERY);
    add_step(FUNC_QUERY, 8'hFF, 1'b1, 40'hFF_FFFF_FFFF, 1'b1, NO_SCHEMA_QUERY);
    add_step(FUNC_BLOB, MAGIC0, 1'b1, 40'h00_0000_0000, 1'b1, FAILED_LOAD);
    add_step(FUNC_BLOB, 8'hFF, 1'b1, 40'hFF_FFFF_FFFF, 1'b1, FAILED_LOAD);
    add_step(FUNC_BLOB, MAGIC0, 1'b0, '0, 1'b0, NO_SCHEMA_QUERY);
    add_step(FUNC_BLOB, MAGIC1, 1'b0, '0, 1'b0, NO_SCHEMA_QUERY);
    add_step(FUNC_BLOB, MAGIC2, 1'b0, '0, 1'b0, NO_SCHEMA_QUERY);
    add_step(FUNC_BLOB, MAGIC3, 1'b0, '0, 1'b0, NO_SCHEMA_QUERY);
    add_step(FUNC_BLOB, VERSION_LO, 1'b0, '0, 1'b0, NO_SCHEMA_QUERY);
    add_step(FUNC_QUERY, 8'h00, 1'b0, 40'hF0_0FAA_5500, 1'b1, NO_SCHEMA_QUERY);
    add_step(FUNC_BLOB, VERSION_HI, 1'b0, '0, 1'b0, NO_SCHEMA_QUERY);
    add_step(FUNC_BLOB, ROW_HDR0, 1'b0, '0, 1'b0, NO_SCHEMA_QUERY);
    add_step(FUNC_BLOB, ROW_HDR1, 1'b0, '0, 1'b0, NO_SCHEMA_QUERY);
    add_step(FUNC_BLOB, 8'hFF, 1'b0, '0, 1'b0, NO_SCHEMA_QUERY);
    add_step(FUNC_BLOB, 8'h00, 1'b0, '0, 1'b0, NO_SCHEMA_QUERY);
    add_step(FUNC_BLOB, 8'hFF, 1'b0, '0, 1'b0, NO_SCHEMA_QUERY);
    add_step(FUNC_BLOB, 8'hFF, 1'b0, '0, 1'b0, NO_SCHEMA_QUERY);
    add_step(FUNC_BLOB, 8'h01, 1'b0, '0, 1'b0, NO_SCHEMA_QUERY);
    add_step(FUNC_BLOB, 8'h00, 1'b0, '0, 1'b0, NO_SCHEMA_QUERY);
    add_step(FUNC_BLOB, 8'h55, 1'b0, '0, 1'b0, NO_SCHEMA_QUERY);
    add_step(FUNC_BLOB, 8'hAA, 1'b0, '0, 1'b0, NO_SCHEMA_QUERY);
    add_step(FUNC_BLOB, 8'h0F, 1'b0, '0, 1'b0, NO_SCHEMA_QUERY);
    add_step(FUNC_BLOB, 8'hF0, 1'b1, '0, 1'b1,
             '{KIND_LOAD, 1'b1, 1'b0, 8'hFF, 8'h00, 16'hFFFF});
    add_step(FUNC_QUERY, 8'h00, 1'b0, 40'hF0_0FAA_5500, 1'b0, NO_SCHEMA_QUERY);
    add_step(FUNC_QUERY, 8'h00, 1'b0, 40'hF0_0FAA_5501, 1'b0, NO_SCHEMA_QUERY);
    add_step(FUNC_QUERY, 8'h00, 1'b0, 40'hFF_0FAA_5500, 1'b0, NO_SCHEMA_QUERY);

    // Hold reset, then release it on a rising edge
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i])
      issue(directed[i].f, directed[i].b, directed[i].last, directed[i].a,
            directed[i].pinned, directed[i].want);

    // Random part: mostly well-formed blobs with random content, followed
    // by bursts of queries aimed at the rows just loaded
    while (items_sent < RANDOM_ITEMS + directed.size()) random_episode();

    // Last stretch runs without idling: a few more episodes back to back
    idle_gaps = 1'b0;
    repeat (3) random_episode();

    start <= 1'b0;

    // Drain every outstanding reply, then idle through one worst-case scan
    for (w = 0; w < DRAIN_LIMIT && replies_due.size() != 0; w++) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (replies_due.size() != 0) report("replies never delivered", replies_due.size(), 0);

    $display("sent %0d transactions; %0d load replies (%0d loaded), %0d query replies",
             items_sent, loads_seen, loads_good, queries_seen);
    $display("%0d queries matched a stored prefix; %0d mismatches", hits_seen, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
